[hdl/triangle_primitive_assembler_assert.svh]
// assertion macros for the triangle primitive assembler checker
// no dependencies; the including scope provides clk_i and rst_ni
`ifndef TRIANGLE_PRIMITIVE_ASSEMBLER_ASSERT_SVH
`define TRIANGLE_PRIMITIVE_ASSEMBLER_ASSERT_SVH

// checked on every edge out of reset
`define TPA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked on every edge, reset included
`define TPA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[hdl/tpa_pkg.sv]
// shared types and constants of the triangle primitive assembler
// no dependencies
package tpa_pkg;

  localparam int unsigned VtxW = 32;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [VtxW-1:0] ALL_ONES = 32'hffff_ffff;

  // register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] REG_TOPOLOGY      = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_INDEX_WIDTH   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_RESTART_INDEX = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_BASE_VERTEX   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_VERTEX_LIMIT  = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_FLIP_WINDING  = 3'd5;

  typedef enum logic [1:0] {
    TOPO_LIST  = 2'd0,
    TOPO_STRIP = 2'd1,
    TOPO_FAN   = 2'd2
  } topo_e;

  typedef enum logic [1:0] {
    IDXW_BYTE = 2'd0,
    IDXW_HALF = 2'd1,
    IDXW_WORD = 2'd2
  } idxw_e;

  typedef struct packed {
    logic [1:0]      topology;
    logic [1:0]      index_width;
    logic [VtxW-1:0] restart_index;
    logic [VtxW-1:0] base_vertex;
    logic [VtxW-1:0] vertex_limit;
    logic            flip_winding;
  } cfg_t;

  // classified word from front to back
  typedef struct packed {
    logic            restart;
    logic            last;
    logic [VtxW-1:0] vertex;
  } mid_t;

  // one emitted triangle
  typedef struct packed {
    logic [VtxW-1:0] vertex_a;
    logic [VtxW-1:0] vertex_b;
    logic [VtxW-1:0] vertex_c;
    logic            dropped;
    logic [VtxW-1:0] dropped_count;
  } res_t;

endpackage

[hdl/tpa_queue.sv]
// small register queue used between front, back and the result port
// no package dependency
module tpa_queue #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  logic [Width-1:0] wr_data_i,
  output logic             full_o,
  input  logic             rd_en_i,
  output logic [Width-1:0] rd_data_o,
  output logic             empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             wr, rd;

  assign full_o    = (cnt_q == CntW'(Depth));
  assign empty_o   = (cnt_q == '0);
  assign wr        = wr_en_i && !full_o;
  assign rd        = rd_en_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (rd) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (wr && !rd) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (rd && !wr) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage, no reset
  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

[hdl/tpa_front.sv]
// front end: masks the raw index, detects restart and applies the base vertex
// depends on tpa_pkg
module tpa_front import tpa_pkg::*; (
  input  cfg_t            cfg_i,
  input  logic [VtxW-1:0] raw_index_i,
  input  logic            last_index_i,
  output mid_t            word_o
);

  logic [VtxW-1:0] masked;
  logic [VtxW-1:0] sub;
  logic [VtxW-1:0] adjusted;
  logic            hit_restart;

  // mask to the configured index size; code three keeps all bits
  always_comb begin
    unique case (cfg_i.index_width)
      IDXW_BYTE: masked = {24'd0, raw_index_i[7:0]};
      IDXW_HALF: masked = {16'd0, raw_index_i[15:0]};
      default:   masked = raw_index_i;
    endcase
  end

  assign hit_restart = (cfg_i.restart_index != '0) && (masked == cfg_i.restart_index);

  // negative base clamps at zero, positive base wraps
  assign sub = '0 - cfg_i.base_vertex;
  always_comb begin
    if (cfg_i.base_vertex[VtxW-1]) begin
      adjusted = (masked < sub) ? '0 : masked - sub;
    end else begin
      adjusted = masked + cfg_i.base_vertex;
    end
  end

  assign word_o.restart = hit_restart || (adjusted == ALL_ONES);
  assign word_o.last    = last_index_i;
  assign word_o.vertex  = adjusted;

endmodule

[hdl/tpa_back.sv]
// back end: run state, list/strip/fan assembly, range check and drop count
// depends on tpa_pkg
module tpa_back import tpa_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic mid_valid_i,
  input  mid_t mid_word_i,
  output logic mid_take_o,
  input  logic res_full_i,
  output logic res_push_o,
  output res_t res_word_o
);

  logic [1:0]      run_fill_q, run_fill_d;
  logic            strip_odd_q, strip_odd_d;
  logic [VtxW-1:0] fan_anchor_q, fan_anchor_d;
  logic [VtxW-1:0] older_q, older_d;
  logic [VtxW-1:0] newer_q, newer_d;
  logic [VtxW-1:0] dropped_total_q, dropped_total_d;

  logic            topo_ok;
  logic            emit;
  logic            drop;
  logic [VtxW-1:0] va, vb, vc;

  assign mid_take_o = mid_valid_i && !res_full_i;
  assign topo_ok    = (cfg_i.topology == TOPO_LIST) || (cfg_i.topology == TOPO_STRIP) ||
                      (cfg_i.topology == TOPO_FAN);

  // assembly of the next word
  always_comb begin
    run_fill_d   = run_fill_q;
    strip_odd_d  = strip_odd_q;
    fan_anchor_d = fan_anchor_q;
    older_d      = older_q;
    newer_d      = newer_q;
    emit         = 1'b0;
    va           = older_q;
    vb           = newer_q;
    vc           = mid_word_i.vertex;
    if (mid_take_o) begin
      if (mid_word_i.restart) begin
        run_fill_d  = 2'd0;
        strip_odd_d = 1'b0;
      end else if (topo_ok) begin
        case (run_fill_q)
          2'd0: begin
            older_d      = mid_word_i.vertex;
            fan_anchor_d = mid_word_i.vertex;
            run_fill_d   = 2'd1;
          end
          2'd1: begin
            newer_d    = mid_word_i.vertex;
            run_fill_d = 2'd2;
          end
          default: begin
            emit = 1'b1;
            case (cfg_i.topology)
              TOPO_STRIP: begin
                if (strip_odd_q) begin
                  va = newer_q;
                  vb = older_q;
                end
                older_d     = newer_q;
                newer_d     = mid_word_i.vertex;
                strip_odd_d = !strip_odd_q;
              end
              TOPO_FAN: begin
                va      = fan_anchor_q;
                newer_d = mid_word_i.vertex;
              end
              default: begin
                run_fill_d = 2'd0;
              end
            endcase
          end
        endcase
      end
      // last flag ends the run after the word
      if (mid_word_i.last) begin
        run_fill_d  = 2'd0;
        strip_odd_d = 1'b0;
      end
    end
  end

  // range check and running drop total
  assign drop = (va >= cfg_i.vertex_limit) || (vb >= cfg_i.vertex_limit) ||
                (vc >= cfg_i.vertex_limit);
  assign dropped_total_d = (emit && drop) ? dropped_total_q + VtxW'(1) : dropped_total_q;

  assign res_push_o               = emit;
  assign res_word_o.vertex_a      = va;
  assign res_word_o.vertex_b      = cfg_i.flip_winding ? vc : vb;
  assign res_word_o.vertex_c      = cfg_i.flip_winding ? vb : vc;
  assign res_word_o.dropped       = drop;
  assign res_word_o.dropped_count = dropped_total_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_fill_q      <= 2'd0;
      strip_odd_q     <= 1'b0;
      fan_anchor_q    <= '0;
      older_q         <= '0;
      newer_q         <= '0;
      dropped_total_q <= '0;
    end else begin
      run_fill_q      <= run_fill_d;
      strip_odd_q     <= strip_odd_d;
      fan_anchor_q    <= fan_anchor_d;
      older_q         <= older_d;
      newer_q         <= newer_d;
      dropped_total_q <= dropped_total_d;
    end
  end

endmodule

[hdl/triangle_primitive_assembler.sv]
// top level: configuration registers, front end, word queue, back end, result queue
// depends on tpa_pkg, tpa_front, tpa_queue, tpa_back
//
//  channel   handshake      payload
//  index in  push / full    raw_index_i, last_index_i
//  result    empty / pop    vertex_a_o, vertex_b_o, vertex_c_o, dropped_o, dropped_count_o
//  config    cfg_we_i       cfg_index_i, cfg_data_i (write only)
//
// one index word per cycle sustained while results are popped; a word enters the word
// queue at its push edge, and the triangle it completes passes on to the result queue.
// the rate is set by the back end, which updates run state once per word.
// reset clears run state, drop total and both queues; configuration takes its reset values.
// a result stall fills the result queue, then the word queue, then raises full.
module triangle_primitive_assembler import tpa_pkg::*; #(
  parameter int QUEUE_DEPTH  = 2,
  parameter int RESULT_DEPTH = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [VtxW-1:0]    raw_index_i,
  input  logic               last_index_i,
  output logic               empty,
  input  logic               pop,
  output logic [VtxW-1:0]    vertex_a_o,
  output logic [VtxW-1:0]    vertex_b_o,
  output logic [VtxW-1:0]    vertex_c_o,
  output logic               dropped_o,
  output logic [VtxW-1:0]    dropped_count_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [VtxW-1:0]    cfg_data_i
);

  cfg_t cfg_q;
  mid_t front_word;
  mid_t mid_word;
  res_t back_word;
  res_t res_word;

  logic [$bits(mid_t)-1:0] mid_rd_data;
  logic [$bits(res_t)-1:0] res_rd_data;
  logic                    mid_empty;
  logic                    mid_take;
  logic                    res_full;
  logic                    res_push;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.topology      <= TOPO_LIST;
      cfg_q.index_width   <= IDXW_WORD;
      cfg_q.restart_index <= '0;
      cfg_q.base_vertex   <= '0;
      cfg_q.vertex_limit  <= '0;
      cfg_q.flip_winding  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_TOPOLOGY:      cfg_q.topology      <= cfg_data_i[1:0];
        REG_INDEX_WIDTH:   cfg_q.index_width   <= cfg_data_i[1:0];
        REG_RESTART_INDEX: cfg_q.restart_index <= cfg_data_i;
        REG_BASE_VERTEX:   cfg_q.base_vertex   <= cfg_data_i;
        REG_VERTEX_LIMIT:  cfg_q.vertex_limit  <= cfg_data_i;
        REG_FLIP_WINDING:  cfg_q.flip_winding  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // classify incoming index words
  tpa_front u_front (
    .cfg_i        (cfg_q),
    .raw_index_i  (raw_index_i),
    .last_index_i (last_index_i),
    .word_o       (front_word)
  );

  // word queue between front and back
  tpa_queue #(
    .Width ($bits(mid_t)),
    .Depth (QUEUE_DEPTH)
  ) u_mid_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (push),
    .wr_data_i (front_word),
    .full_o    (full),
    .rd_en_i   (mid_take),
    .rd_data_o (mid_rd_data),
    .empty_o   (mid_empty)
  );

  assign mid_word = mid_t'(mid_rd_data);

  // triangle assembly
  tpa_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .mid_valid_i (!mid_empty),
    .mid_word_i  (mid_word),
    .mid_take_o  (mid_take),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_word_o  (back_word)
  );

  // result queue towards the consumer
  tpa_queue #(
    .Width ($bits(res_t)),
    .Depth (RESULT_DEPTH)
  ) u_res_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (res_push),
    .wr_data_i (back_word),
    .full_o    (res_full),
    .rd_en_i   (pop),
    .rd_data_o (res_rd_data),
    .empty_o   (empty)
  );

  assign res_word        = res_t'(res_rd_data);
  assign vertex_a_o      = res_word.vertex_a;
  assign vertex_b_o      = res_word.vertex_b;
  assign vertex_c_o      = res_word.vertex_c;
  assign dropped_o       = res_word.dropped;
  assign dropped_count_o = res_word.dropped_count;

endmodule

[hdl/tpa_checker.sv]
// port-level checker for the triangle primitive assembler, bound to the top level
// depends on triangle_primitive_assembler_assert.svh
`include "triangle_primitive_assembler_assert.svh"

module tpa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pop,
  input logic [31:0] vertex_a_o,
  input logic [31:0] vertex_b_o,
  input logic [31:0] vertex_c_o,
  input logic        dropped_o,
  input logic [31:0] dropped_count_o
);

  // nothing waits on the result side while reset is held
  `TPA_ASSERT_ALWAYS(a_reset_empty, !rst_ni |-> empty, "result waiting during reset")

  // the drop total of each result builds on the one before it
  `TPA_ASSERT(a_count_chain, (pop && !empty) ##1 !empty |-> dropped_count_o == ($past(dropped_count_o) + {31'd0, dropped_o}), "drop total does not follow previous result")

  // a waiting result holds until it is taken
  `TPA_ASSERT(a_result_hold, (!empty && !pop) |=> (!empty && $stable(vertex_a_o) && $stable(vertex_b_o) && $stable(vertex_c_o) && $stable(dropped_o)), "waiting result changed")

endmodule

bind triangle_primitive_assembler tpa_checker u_checker (.*);

[test/tb_top.sv]
// self-checking testbench for triangle_primitive_assembler: index words in, triangles out
// depends on tpa_pkg and the assembler rtl; carries its own assembly predictor and scoreboard
`timescale 1ns / 1ps

module tb_top;
  import tpa_pkg::*;

  // codes outside the package enums that the registers still accept
  localparam logic [1:0] TOPO_NONE = 2'd3;
  localparam logic [1:0] IDXW_WIDE = 2'd3;

  localparam int SETTLE_CYCLES     = 4;
  localparam int WATCHDOG_LIMIT    = 4000;
  localparam int ITEMS_PER_SETTING = 56;
  localparam int MAX_REPORTS       = 40;

  // predicts triangles from accepted index words and checks the emitted ones
  class triangle_tracker;
    logic [1:0]      topology;
    logic [1:0]      index_width;
    logic [VtxW-1:0] restart_index;
    logic [VtxW-1:0] base_vertex;
    logic [VtxW-1:0] vertex_limit;
    logic            flip_winding;
    logic [1:0]      run_fill;
    logic            strip_odd;
    logic [VtxW-1:0] fan_anchor;
    logic [VtxW-1:0] older_vertex;
    logic [VtxW-1:0] newer_vertex;
    logic [VtxW-1:0] dropped_total;
    res_t            pending_tris[$];
    int unsigned     errors;
    int unsigned     indexes_seen;
    int unsigned     tris_checked;
    int unsigned     drops_checked;

    function new();
      topology      = TOPO_LIST;
      index_width   = IDXW_WORD;
      restart_index = '0;
      base_vertex   = '0;
      vertex_limit  = '0;
      flip_winding  = 1'b0;
      run_fill      = '0;
      strip_odd     = 1'b0;
      fan_anchor    = '0;
      older_vertex  = '0;
      newer_vertex  = '0;
      dropped_total = '0;
      errors        = 0;
      indexes_seen  = 0;
      tris_checked  = 0;
      drops_checked = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [VtxW-1:0] data);
      case (idx)
        REG_TOPOLOGY:      topology      = data[1:0];
        REG_INDEX_WIDTH:   index_width   = data[1:0];
        REG_RESTART_INDEX: restart_index = data;
        REG_BASE_VERTEX:   base_vertex   = data;
        REG_VERTEX_LIMIT:  vertex_limit  = data;
        REG_FLIP_WINDING:  flip_winding  = data[0];
        default: ;
      endcase
    endfunction

    // range check, drop count and winding flip of one triangle
    function void add_triangle(logic [VtxW-1:0] a, logic [VtxW-1:0] b, logic [VtxW-1:0] c);
      res_t triangle;
      logic drop;
      drop = (a >= vertex_limit) || (b >= vertex_limit) || (c >= vertex_limit);
      if (drop) dropped_total = dropped_total + 1;
      triangle.vertex_a      = a;
      triangle.vertex_b      = flip_winding ? c : b;
      triangle.vertex_c      = flip_winding ? b : c;
      triangle.dropped       = drop;
      triangle.dropped_count = dropped_total;
      pending_tris.insert(pending_tris.size(), triangle);
    endfunction

    function void note_index(logic [VtxW-1:0] raw, logic last);
      logic [VtxW-1:0] vtx;
      logic [VtxW-1:0] offset;
      logic            restart;
      indexes_seen++;
      vtx = raw;
      if (index_width == IDXW_BYTE) vtx = vtx & 32'h0000_00ff;
      else if (index_width == IDXW_HALF) vtx = vtx & 32'h0000_ffff;
      restart = 1'b0;
      // restart match is on the masked value, before the base is applied
      if (restart_index != '0 && vtx == restart_index) begin
        restart = 1'b1;
      end else begin
        if (base_vertex[VtxW-1]) begin
          offset = -base_vertex;
          vtx = (vtx < offset) ? '0 : vtx - offset;
        end else begin
          vtx = vtx + base_vertex;
        end
        if (vtx == ALL_ONES) restart = 1'b1;
      end
      // assembly of the run
      if (restart) begin
        run_fill  = '0;
        strip_odd = 1'b0;
      end else if (topology <= TOPO_FAN) begin
        if (run_fill == 2'd0) begin
          older_vertex = vtx;
          fan_anchor   = vtx;
          run_fill     = 2'd1;
        end else if (run_fill == 2'd1) begin
          newer_vertex = vtx;
          run_fill     = 2'd2;
        end else if (topology == TOPO_LIST) begin
          add_triangle(older_vertex, newer_vertex, vtx);
          run_fill = 2'd0;
        end else if (topology == TOPO_STRIP) begin
          if (strip_odd) add_triangle(newer_vertex, older_vertex, vtx);
          else add_triangle(older_vertex, newer_vertex, vtx);
          older_vertex = newer_vertex;
          newer_vertex = vtx;
          strip_odd    = ~strip_odd;
        end else begin
          add_triangle(fan_anchor, newer_vertex, vtx);
          newer_vertex = vtx;
        end
      end
      if (last) begin
        run_fill  = '0;
        strip_odd = 1'b0;
      end
    endfunction

    function void compare_field(string field, logic [VtxW-1:0] want, logic [VtxW-1:0] got);
      if (want !== got) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
      end
    endfunction

    function void check_triangle(res_t got);
      res_t want;
      if (pending_tris.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected triangle, expected none actual %h %h %h", $time,
                   got.vertex_a, got.vertex_b, got.vertex_c);
      end else begin
        want = pending_tris.pop_front();
        tris_checked++;
        if (want.dropped) drops_checked++;
        compare_field("vertex_a", want.vertex_a, got.vertex_a);
        compare_field("vertex_b", want.vertex_b, got.vertex_b);
        compare_field("vertex_c", want.vertex_c, got.vertex_c);
        compare_field("dropped", {31'd0, want.dropped}, {31'd0, got.dropped});
        compare_field("dropped_count", want.dropped_count, got.dropped_count);
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               push;
  logic               full;
  logic [VtxW-1:0]    raw_index_i;
  logic               last_index_i;
  logic               empty;
  logic               pop;
  logic [VtxW-1:0]    vertex_a_o;
  logic [VtxW-1:0]    vertex_b_o;
  logic [VtxW-1:0]    vertex_c_o;
  logic               dropped_o;
  logic [VtxW-1:0]    dropped_count_o;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [VtxW-1:0]    cfg_data_i;

  triangle_tracker tracker;
  res_t            seen;
  int unsigned     send_idle_pct;
  int unsigned     recv_stall_pct;
  int unsigned     quiet_cycles;
  int unsigned     settings_used;

  triangle_primitive_assembler uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .raw_index_i     (raw_index_i),
    .last_index_i    (last_index_i),
    .empty           (empty),
    .pop             (pop),
    .vertex_a_o      (vertex_a_o),
    .vertex_b_o      (vertex_b_o),
    .vertex_c_o      (vertex_c_o),
    .dropped_o       (dropped_o),
    .dropped_count_o (dropped_count_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // result side: random stalls on pop
  initial begin
    pop <= 1'b0;
    forever begin
      @(posedge clk_i);
      pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watch both handshakes, predict on accepted words, check accepted triangles
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) tracker.note_index(raw_index_i, last_index_i);
      if (pop && !empty) begin
        seen.vertex_a      = vertex_a_o;
        seen.vertex_b      = vertex_b_o;
        seen.vertex_c      = vertex_c_o;
        seen.dropped       = dropped_o;
        seen.dropped_count = dropped_count_o;
        tracker.check_triangle(seen);
      end
      if ((push && !full) || (pop && !empty)) quiet_cycles = 0;
      else quiet_cycles++;
    end
  end

  // watchdog on cycles without any accepted word or triangle
  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk_i);
    $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
    $display("FAIL");
    $finish;
  end

  task automatic send_index(input logic [VtxW-1:0] raw, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push         <= 1'b1;
    raw_index_i  <= raw;
    last_index_i <= last;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
  endtask

  // wait for every expected triangle, then for words still in the pipe
  task automatic settle_block();
    push <= 1'b0;
    do @(posedge clk_i); while (tracker.pending_tris.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [VtxW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    tracker.set_reg(idx, data);
  endtask

  task automatic program_regs(input logic [1:0] topo, input logic [1:0] idxw,
                              input logic [VtxW-1:0] restart, input logic [VtxW-1:0] base,
                              input logic [VtxW-1:0] limit, input logic flip);
    write_reg(REG_TOPOLOGY, {30'd0, topo});
    write_reg(REG_INDEX_WIDTH, {30'd0, idxw});
    write_reg(REG_RESTART_INDEX, restart);
    write_reg(REG_BASE_VERTEX, base);
    write_reg(REG_VERTEX_LIMIT, limit);
    write_reg(REG_FLIP_WINDING, {31'd0, flip});
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  // random setting with the extremes weighted in
  task automatic random_settings();
    logic [1:0]      topo;
    logic [1:0]      idxw;
    logic [VtxW-1:0] restart;
    logic [VtxW-1:0] base;
    logic [VtxW-1:0] limit;
    topo = ($urandom_range(9) == 0) ? TOPO_NONE : 2'($urandom_range(2));
    idxw = 2'($urandom_range(3));
    case ($urandom_range(4))
      0, 1:    restart = '0;
      2:       restart = $urandom_range(1, 47);
      3:       restart = ($urandom_range(1) == 0) ? 32'h0000_00ff : 32'h0000_ffff;
      default: restart = $urandom();
    endcase
    case ($urandom_range(6))
      0, 1:    base = '0;
      2:       base = 32'h8000_0000;
      3:       base = 32'h7fff_ffff;
      4:       base = -$urandom_range(1, 20);
      5:       base = $urandom_range(1, 20);
      default: base = $urandom();
    endcase
    case ($urandom_range(4))
      0:       limit = '0;
      1:       limit = ALL_ONES;
      2, 3:    limit = $urandom_range(8, 60);
      default: limit = $urandom();
    endcase
    program_regs(topo, idxw, restart, base, limit, 1'($urandom_range(1)));
  endtask

  // mostly small vertex ids, with restarts, all-ones hits and full-width noise
  function automatic logic [VtxW-1:0] pick_raw();
    int unsigned     sel;
    logic [VtxW-1:0] raw;
    sel = $urandom_range(99);
    if (sel < 8 && tracker.restart_index != '0) raw = tracker.restart_index;
    else if (sel < 12) raw = ALL_ONES - tracker.base_vertex;
    else if (sel < 20) raw = $urandom();
    else begin
      raw = $urandom_range(47);
      if ($urandom_range(3) == 0) raw[VtxW-1:16] = 16'($urandom());
    end
    return raw;
  endfunction

  initial begin
    rst_ni         <= 1'b0;
    push           <= 1'b0;
    raw_index_i    <= '0;
    last_index_i   <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_index_i    <= REG_TOPOLOGY;
    cfg_data_i     <= '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    quiet_cycles   = 0;
    settings_used  = 0;
    tracker        = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // list: in-range, dropped at the limit, all-ones restart, last flag ending a run
    program_regs(TOPO_LIST, IDXW_WORD, '0, '0, 32'd10, 1'b0);
    send_index(32'd0, 1'b0);
    send_index(32'd1, 1'b0);
    send_index(32'd2, 1'b0);
    send_index(32'd9, 1'b0);
    send_index(32'd10, 1'b0);
    send_index(32'd3, 1'b0);
    send_index(ALL_ONES, 1'b0);
    send_index(32'd4, 1'b0);
    send_index(32'd5, 1'b0);
    send_index(32'd6, 1'b1);
    settle_block();

    // strip with flip, half-word mask, restart value, negative base clamping at zero
    program_regs(TOPO_STRIP, IDXW_HALF, 32'h0000_1234, 32'hffff_fffd, ALL_ONES, 1'b1);
    send_index(32'habcd_0005, 1'b0);
    send_index(32'h0000_1234, 1'b0);
    send_index(32'd1, 1'b0);
    send_index(32'd4, 1'b0);
    send_index(32'd5, 1'b0);
    send_index(32'd6, 1'b0);
    send_index(32'd7, 1'b1);
    settle_block();

    // fan with byte mask, largest positive base, restart on the masked byte
    program_regs(TOPO_FAN, IDXW_BYTE, 32'h0000_00ff, 32'h7fff_ffff, 32'h8000_0010, 1'b0);
    send_index(32'h0000_0100, 1'b0);
    send_index(32'h0000_0201, 1'b0);
    send_index(32'h0000_0302, 1'b0);
    send_index(32'hffff_ffff, 1'b0);
    send_index(32'd5, 1'b0);
    send_index(32'd6, 1'b0);
    settle_block();

    // topology with no triangles, index width three, most negative base
    program_regs(TOPO_NONE, IDXW_WIDE, '0, 32'h8000_0000, '0, 1'b1);
    send_index(32'h8000_0001, 1'b0);
    send_index(32'hffff_fffe, 1'b0);
    send_index(32'd3, 1'b0);

    // random part over the idling phases
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct  = (phase == 1) ? 47 : (phase == 3) ? 22 : 0;
      recv_stall_pct = (phase == 2) ? 47 : (phase == 3) ? 22 : 0;
      for (int s = 0; s < 4; s++) begin
        settle_block();
        random_settings();
        repeat (ITEMS_PER_SETTING) send_index(pick_raw(), $urandom_range(19) == 0);
      end
    end

    settle_block();
    repeat (10) @(posedge clk_i);
    $display("sent %0d index words over %0d register settings and four idling phases",
             tracker.indexes_seen, settings_used);
    $display("checked %0d triangles, %0d of them flagged as dropped",
             tracker.tris_checked, tracker.drops_checked);
    if (tracker.errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
